FILE: rtl/dcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcc_pkg
// Shared types and constants of the delimited cell type classifier.
// ----------------------------------------------------------------------------
package dcc_pkg;

	localparam int INT_WIDTH = 32;
	localparam logic [INT_WIDTH-1:0] INT_LIMIT = {1'b1, {(INT_WIDTH-1){1'b0}}};

	typedef enum logic [1:0] {
		CLASS_INTEGER = 2'd0,
		CLASS_DOUBLE  = 2'd1,
		CLASS_STRING  = 2'd2
	} cell_class_t;

	typedef struct packed {
		cell_class_t        cell_class;
		logic signed [31:0] integer_value;
		logic               integer_saturated;
		logic               ended_line;
	} dcc_result_t;

endpackage
`default_nettype wire

FILE: rtl/dcc_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcc_scanner
// Per-byte cell scanner: tracks the open cell and builds its result word
// when a delimiter, newline or flush closes it.
// ----------------------------------------------------------------------------
module dcc_scanner
	import dcc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        step,
	input  wire logic [7:0]  text_byte,
	input  wire logic        flush,
	input  wire logic        comma_mode,
	output logic             res_fire,
	output dcc_result_t      res
);

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_LEAD    = 4'd1,
		PH_SIGN    = 4'd2,
		PH_INT     = 4'd3,
		PH_FRAC    = 4'd4,
		PH_EXP     = 4'd5,
		PH_EXPSIGN = 4'd6,
		PH_EXPDIG  = 4'd7,
		PH_OTHER   = 4'd8,
		PH_TRAIL   = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		W_NONE  = 3'd0,
		W_I     = 3'd1,
		W_IN    = 3'd2,
		W_INF   = 3'd3,
		W_N     = 3'd4,
		W_NA    = 3'd5,
		W_NAN   = 3'd6,
		W_MINUS = 3'd7
	} word_t;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_UC_E  = 8'h45;
	localparam logic [7:0] CH_LC_E  = 8'h65;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_F  = 8'h66;
	localparam logic [7:0] CH_LC_I  = 8'h69;
	localparam logic [7:0] CH_LC_N  = 8'h6E;

	localparam int SUM_W = INT_WIDTH + 4;

	phase_t                 phase_q, phase_n, ph_cur, np;
	word_t                  word_q, word_n;
	logic                   si_q, si_n, sd_q, sd_n;
	logic                   neg_q, neg_n, mds_q, mds_n, ovf_q, ovf_n;
	logic [INT_WIDTH-1:0]   acc_q, acc_n;

	logic [7:0]             delim;
	logic                   newline, close_cell;
	logic                   is_digit, is_sign, is_dot, is_expo;
	logic [1:0]             verdict;
	logic [SUM_W-1:0]       acc_x, acc_sum;
	logic [63:0]            acc_wide, acc_neg;

	function automatic word_t word_next(word_t w, logic [7:0] ch, logic first);
		logic [7:0] lc;
		word_t      r;
		lc = ch;
		if (ch >= CH_UC_A && ch <= CH_UC_Z) begin
			lc = ch + 8'd32;
		end
		r = W_NONE;
		if (first) begin
			if (lc == CH_LC_I) r = W_I;
			else if (lc == CH_LC_N) r = W_N;
			else if (lc == CH_MINUS) r = W_MINUS;
		end else begin
			if (w == W_I && lc == CH_LC_N) r = W_IN;
			else if (w == W_IN && lc == CH_LC_F) r = W_INF;
			else if (w == W_N && lc == CH_LC_A) r = W_NA;
			else if (w == W_NA && lc == CH_LC_N) r = W_NAN;
			else if (w == W_MINUS && lc == CH_LC_I) r = W_I;
		end
		return r;
	endfunction

	// Returns {is_integer, is_double} for a cell whose content ends in phase p.
	function automatic logic [1:0] settle(phase_t p, word_t w, logic si, logic sd,
			logic mds);
		logic word_hit;
		logic [1:0] r;
		word_hit = (w == W_INF) || (w == W_NAN);
		if (p == PH_TRAIL) begin
			r = {si, sd};
		end else begin
			r[1] = si && (p == PH_INT);
			r[0] = word_hit || (sd && mds &&
				(p == PH_INT || p == PH_FRAC || p == PH_EXPDIG));
		end
		return r;
	endfunction

	assign delim      = comma_mode ? CH_COMMA : CH_TAB;
	assign newline    = !flush && (text_byte == CH_LF);
	assign close_cell = flush || newline || (text_byte == delim);
	assign is_digit   = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
	assign is_sign    = (text_byte == CH_PLUS) || (text_byte == CH_MINUS);
	assign is_dot     = (text_byte == CH_DOT);
	assign is_expo    = (text_byte == CH_LC_E) || (text_byte == CH_UC_E);

	assign acc_x    = SUM_W'(acc_q);
	assign acc_sum  = (acc_x << 3) + (acc_x << 1) + SUM_W'(text_byte - CH_ZERO);
	assign acc_wide = 64'(acc_q);
	assign acc_neg  = 64'd0 - acc_wide;

	always_comb begin
		phase_n  = phase_q;
		word_n   = word_q;
		si_n     = si_q;
		sd_n     = sd_q;
		neg_n    = neg_q;
		mds_n    = mds_q;
		ovf_n    = ovf_q;
		acc_n    = acc_q;
		ph_cur   = phase_q;
		np       = PH_OTHER;
		verdict  = 2'b00;
		res_fire = 1'b0;
		res.cell_class        = CLASS_STRING;
		res.integer_value     = '0;
		res.integer_saturated = 1'b0;
		res.ended_line        = flush || newline;

		if (step) begin
			if (close_cell) begin
				if (phase_q != PH_IDLE) begin
					res_fire = 1'b1;
					if (phase_q != PH_LEAD) begin
						verdict = settle(phase_q, word_q, si_q, sd_q, mds_q);
					end
					if (verdict[1]) begin
						res.cell_class = CLASS_INTEGER;
						if (neg_q) begin
							res.integer_value     = acc_neg[31:0];
							res.integer_saturated = ovf_q;
						end else if (acc_q >= INT_LIMIT) begin
							res.integer_value     = 32'(64'(INT_LIMIT) - 64'd1);
							res.integer_saturated = 1'b1;
						end else begin
							res.integer_value = acc_wide[31:0];
						end
					end else if (verdict[0]) begin
						res.cell_class = CLASS_DOUBLE;
					end
				end
				phase_n = PH_IDLE;
				word_n  = W_NONE;
				si_n    = 1'b1;
				sd_n    = 1'b1;
				neg_n   = 1'b0;
				mds_n   = 1'b0;
				ovf_n   = 1'b0;
				acc_n   = '0;
			end else begin
				ph_cur  = (phase_q == PH_IDLE) ? PH_LEAD : phase_q;
				phase_n = ph_cur;
				if (text_byte == CH_SPACE) begin
					if (ph_cur != PH_LEAD && ph_cur != PH_TRAIL) begin
						verdict = settle(ph_cur, word_q, si_q, sd_q, mds_q);
						si_n    = verdict[1];
						sd_n    = verdict[0];
						phase_n = PH_TRAIL;
					end
				end else if (ph_cur == PH_TRAIL) begin
					phase_n = PH_OTHER;
					si_n    = 1'b0;
					sd_n    = 1'b0;
					word_n  = W_NONE;
				end else begin
					word_n = word_next(word_q, text_byte, ph_cur == PH_LEAD);
					unique case (ph_cur)
						PH_LEAD: begin
							np = is_sign ? PH_SIGN : is_digit ? PH_INT :
								is_dot ? PH_FRAC : is_expo ? PH_EXP : PH_OTHER;
							if (text_byte == CH_MINUS) neg_n = 1'b1;
						end
						PH_SIGN, PH_INT: begin
							np = is_digit ? PH_INT : is_dot ? PH_FRAC :
								is_expo ? PH_EXP : PH_OTHER;
						end
						PH_FRAC: begin
							np = is_digit ? PH_FRAC : is_expo ? PH_EXP : PH_OTHER;
						end
						PH_EXP: begin
							np = is_sign ? PH_EXPSIGN : is_digit ? PH_EXPDIG : PH_OTHER;
						end
						PH_EXPSIGN, PH_EXPDIG: begin
							np = is_digit ? PH_EXPDIG : PH_OTHER;
						end
						default: begin
							np = PH_OTHER;
						end
					endcase
					if (is_digit && (np == PH_INT || np == PH_FRAC)) mds_n = 1'b1;
					if (np == PH_INT && is_digit && !ovf_q) begin
						if (acc_sum > SUM_W'(INT_LIMIT)) begin
							ovf_n = 1'b1;
							acc_n = INT_LIMIT;
						end else begin
							acc_n = acc_sum[INT_WIDTH-1:0];
						end
					end
					si_n = (np == PH_SIGN) || (np == PH_INT);
					if (np == PH_OTHER) sd_n = 1'b0;
					phase_n = np;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			word_q  <= W_NONE;
			si_q    <= 1'b1;
			sd_q    <= 1'b1;
			neg_q   <= 1'b0;
			mds_q   <= 1'b0;
			ovf_q   <= 1'b0;
			acc_q   <= '0;
		end else begin
			phase_q <= phase_n;
			word_q  <= word_n;
			si_q    <= si_n;
			sd_q    <= sd_n;
			neg_q   <= neg_n;
			mds_q   <= mds_n;
			ovf_q   <= ovf_n;
			acc_q   <= acc_n;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/dcc_out_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dcc_out_queue
// Two-entry result register that lets the scanner keep taking bytes while a
// finished result waits for the consumer.
// ----------------------------------------------------------------------------
module dcc_out_queue
	import dcc_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire dcc_result_t  push_data,
	output logic              has_room,
	output logic              out_valid,
	input  wire logic         out_ready,
	output dcc_result_t       out_data
);

	localparam logic [1:0] DEPTH = 2'd2;

	dcc_result_t entry_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        pop;

	assign has_room  = (count_q != DEPTH);
	assign out_valid = (count_q != 2'd0);
	assign out_data  = entry_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/delimited_cell_type_classifier.sv
`default_nettype none
// ----------------------------------------------------------------------------
// delimited_cell_type_classifier
// Splits a byte stream into cells and reports each cell as integer, double
// or string, with the saturated integer value.
//
//   Channel  Handshake             Word
//   in       in_valid / in_ready   text_byte, flush
//   out      out_valid / out_ready cell_class, integer_value,
//                                  integer_saturated, ended_line
//   cfg      cfg_valid / cfg_ready comma_delimited
//
// One byte is taken every cycle; a closing byte writes its result into a
// two-entry output queue, and bytes stall only when that queue is full.
// A result is registered into the output queue when its closing byte is taken.
// Reset clears the open cell and selects tab as the delimiter.
// ----------------------------------------------------------------------------
module delimited_cell_type_classifier
	import dcc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         text_byte,
	input  wire logic               flush,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              cell_class,
	output logic signed [31:0]      integer_value,
	output logic                    integer_saturated,
	output logic                    ended_line,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               comma_delimited
);

	logic        comma_delimited_q;
	logic        step;
	logic        res_fire;
	dcc_result_t res;
	dcc_result_t out_data;

	assign cfg_ready = 1'b1;
	assign step      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comma_delimited_q <= 1'b0;
		end else if (cfg_valid) begin
			comma_delimited_q <= comma_delimited;
		end
	end

	dcc_scanner u_scanner (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.text_byte  (text_byte),
		.flush      (flush),
		.comma_mode (comma_delimited_q),
		.res_fire   (res_fire),
		.res        (res)
	);

	dcc_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_fire),
		.push_data (res),
		.has_room  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign cell_class        = out_data.cell_class;
	assign integer_value     = out_data.integer_value;
	assign integer_saturated = out_data.integer_saturated;
	assign ended_line        = out_data.ended_line;

endmodule
`default_nettype wire
